### hw/rtl/rcsd_pkg.sv
// ----------------------------------------------------------------------------
// RTMP chunk stream decoder package
// Shared types and constants: parse phases, the slot record held in the
// per-stream table, result kinds, error codes and register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package rcsd_pkg;

  localparam int SLOTS_DEFAULT = 64;

  localparam logic [16:0] CSID_BASE = 17'd64;
  localparam logic [23:0] TS_ESCAPE = 24'hFFFFFF;
  localparam logic [7:0]  SET_CHUNK_SIZE_TYPE = 8'd1;
  localparam logic [23:0] SET_CHUNK_SIZE_LEN = 24'd4;

  localparam logic [3:0] HDR_LEN_FULL  = 4'd11;
  localparam logic [3:0] HDR_LEN_SAME  = 4'd7;
  localparam logic [3:0] HDR_LEN_DELTA = 4'd3;
  localparam logic [3:0] EXT_TS_BYTES  = 4'd4;

  localparam logic [1:0] FMT_FULL  = 2'd0;
  localparam logic [1:0] FMT_SAME  = 2'd1;
  localparam logic [1:0] FMT_CONT  = 2'd3;

  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_EMPTY   = 2'd1;
  localparam logic [1:0] KIND_ERROR   = 2'd2;

  localparam logic [2:0] ERR_NO_STATE    = 3'd0;
  localparam logic [2:0] ERR_INTERRUPTED = 3'd1;
  localparam logic [2:0] ERR_TOO_LONG    = 3'd2;
  localparam logic [2:0] ERR_ZERO_CHUNK  = 3'd3;
  localparam logic [2:0] ERR_CSID_RANGE  = 3'd4;

  localparam logic [1:0] REG_MAX_LENGTH = 2'd0;
  localparam logic [1:0] REG_INIT_CHUNK = 2'd1;

  localparam logic [23:0] RESET_MAX_LENGTH = 24'hFFFFFF;
  localparam logic [30:0] RESET_CHUNK_SIZE = 31'd128;

  typedef enum logic [2:0] {
    PH_BASIC,
    PH_CSID,
    PH_HDR,
    PH_EXT,
    PH_BODY
  } phase_t;

  typedef struct packed {
    logic        extended;
    logic [31:0] time_abs;
    logic [31:0] delta;
    logic [23:0] length;
    logic [7:0]  mtype;
    logic [31:0] mstream;
    logic [23:0] received;
    logic [31:0] tail;
  } slot_rec_t;

endpackage

`default_nettype wire

### hw/rtl/rcsd_slot_ram.sv
// ----------------------------------------------------------------------------
// RTMP chunk stream slot table
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module rcsd_slot_ram
  import rcsd_pkg::*;
#(
  parameter int DEPTH = SLOTS_DEFAULT,
  parameter int AW = $clog2(DEPTH)
) (
  input  wire logic            clk,
  input  wire logic            we,
  input  wire logic [AW-1:0]   waddr,
  input  wire slot_rec_t       wdata,
  input  wire logic            re,
  input  wire logic [AW-1:0]   raddr,
  output slot_rec_t            rdata
);

  slot_rec_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### hw/rtl/rtmp_chunk_stream_decoder.sv
// ----------------------------------------------------------------------------
// RTMP chunk stream decoder
// Strips chunk framing from a byte stream, one byte per request, and
// emits payload bytes tagged with their message attributes.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake           | payload
//  ---------+-----------+---------------------+-------------------------------
//  in       | input     | in_valid / in_stall | stream_byte
//  out      | output    | out_valid/out_stall | result_kind .. error_code
//  cfg      | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One byte is taken per cycle while in_stall is low. The slot record is read
// at the edge that accepts a byte, the byte is parsed in the parse stage, and
// its result, if any, is registered as that stage advances. A read-modify-write
// of adjacent bytes on the same stream is covered by forwarding the last
// written record. Reset clears the slot valid bits at once; no clearing pass
// is needed. While out_stall holds a result in the output register, one more
// byte can enter the parse stage, and in_stall is high while that byte waits.
`default_nettype none

module rtmp_chunk_stream_decoder
  import rcsd_pkg::*;
#(
  parameter int STREAM_SLOTS = SLOTS_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  stream_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       result_kind,
  output logic [7:0]       payload_byte,
  output logic [16:0]      chunk_stream,
  output logic [7:0]       message_kind,
  output logic [31:0]      message_stream,
  output logic [31:0]      message_time,
  output logic [23:0]      msg_length,
  output logic             last_of_message,
  output logic [2:0]       error_code,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [30:0] cfg_data
);

  localparam int AW = $clog2(STREAM_SLOTS);

  // configuration
  logic [23:0] max_len;

  // parser state
  phase_t      phase, ph_next;
  logic [3:0]  hbc, hbc_next;
  logic [31:0] ha0, ha0_next;
  logic [23:0] ha1, ha1_next;
  logic [7:0]  ha2, ha2_next;
  logic [31:0] ha3, ha3_next;
  logic [1:0]  fmt, fmt_next;
  logic [16:0] cur, cur_next;
  logic [30:0] cbl, cbl_next;
  logic [30:0] acs, acs_next;
  logic        sticky, sticky_next;
  logic        cont, cont_next;
  logic [STREAM_SLOTS-1:0] slot_valid;

  // pipeline
  logic          accept, can_go, adv;
  logic          p1_v;
  logic [7:0]    p1_byte;
  logic [AW-1:0] p1_addr;
  logic [AW-1:0] raddr;
  logic [16:0]   csid_e;
  slot_rec_t     rdata, wrec, rec_in, r;
  logic          fwd_hit;
  logic          rec_we;
  logic          valid_set;

  // stage results
  logic        res_v;
  logic [1:0]  res_kind;
  logic [7:0]  res_byte;
  logic        res_last;
  logic [2:0]  res_code;

  logic        bd_go, hd_go, ap_go, ap_ext, body_go, err_go, emit_go;
  logic [2:0]  err_code;
  logic [1:0]  emit_kind;
  logic        emit_last;
  logic [31:0] field;
  logic [3:0]  need;
  logic [23:0] remaining;
  logic [30:0] csize;
  logic [30:0] req;

  assign cfg_ready = 1'b1;
  assign can_go    = !out_valid || !out_stall;
  assign adv       = p1_v && can_go;
  assign in_stall  = p1_v && !can_go;
  assign accept    = in_valid && !in_stall;
  assign rec_in    = fwd_hit ? wrec : rdata;

  // Slot address of the incoming byte, from the state it will be parsed in.
  always_comb begin
    csid_e = cur_next;
    case (ph_next)
      PH_BASIC: csid_e = {11'd0, stream_byte[5:0]};
      PH_CSID: begin
        if (hbc_next == 4'd1) begin
          csid_e = CSID_BASE + {9'd0, stream_byte};
        end else if (hbc_next == 4'd3) begin
          csid_e = CSID_BASE + cur_next + {1'b0, stream_byte, 8'd0};
        end
      end
      default: csid_e = cur_next;
    endcase
    raddr = csid_e[AW-1:0];
  end

  rcsd_slot_ram #(
    .DEPTH(STREAM_SLOTS),
    .AW   (AW)
  ) u_ram (
    .clk  (clk),
    .we   (rec_we),
    .waddr(p1_addr),
    .wdata(r),
    .re   (accept),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_comb begin
    ph_next = phase; hbc_next = hbc; ha0_next = ha0; ha1_next = ha1;
    ha2_next = ha2; ha3_next = ha3;
    fmt_next = fmt; cur_next = cur; cbl_next = cbl; acs_next = acs;
    sticky_next = sticky;
    cont_next = cont;
    r = rec_in;
    rec_we = 1'b0; valid_set = 1'b0;
    bd_go = 1'b0; hd_go = 1'b0; ap_go = 1'b0; ap_ext = 1'b0; body_go = 1'b0;
    err_go = 1'b0; err_code = ERR_NO_STATE;
    emit_go = 1'b0; emit_kind = KIND_PAYLOAD; emit_last = 1'b0;
    field = 32'd0; remaining = 24'd0; csize = 31'd1; req = 31'd0;
    res_v = 1'b0; res_kind = KIND_PAYLOAD; res_byte = 8'd0; res_last = 1'b0;
    res_code = ERR_NO_STATE;
    need = HDR_LEN_DELTA;

    if (adv && !sticky) begin
      case (phase)
        PH_BASIC: begin
          fmt_next = p1_byte[7:6];
          cur_next = {11'd0, p1_byte[5:0]};
          if (p1_byte[5:1] == 5'd0) begin
            hbc_next = {3'd0, p1_byte[0]} + 4'd1;
            ph_next  = PH_CSID;
          end else begin
            bd_go = 1'b1;
          end
        end
        PH_CSID: begin
          if (hbc == 4'd1) begin
            cur_next = CSID_BASE + {9'd0, p1_byte};
            bd_go = 1'b1;
          end else if (hbc == 4'd2) begin
            cur_next = {9'd0, p1_byte};
            hbc_next = 4'd3;
          end else begin
            cur_next = CSID_BASE + cur + {1'b0, p1_byte, 8'd0};
            bd_go = 1'b1;
          end
        end
        PH_HDR: begin
          if (hbc < 4'd3) begin
            ha0_next = {8'd0, ha0[15:0], p1_byte};
          end else if (hbc < 4'd6) begin
            ha1_next = {ha1[15:0], p1_byte};
          end else if (hbc == 4'd6) begin
            ha2_next = p1_byte;
          end else begin
            case (hbc)
              4'd7:    ha3_next[7:0]   = ha3[7:0]   | p1_byte;
              4'd8:    ha3_next[15:8]  = ha3[15:8]  | p1_byte;
              4'd9:    ha3_next[23:16] = ha3[23:16] | p1_byte;
              4'd10:   ha3_next[31:24] = ha3[31:24] | p1_byte;
              default: ha3_next = ha3;
            endcase
          end
          hbc_next = hbc + 4'd1;
          if (fmt == FMT_FULL) begin
            need = HDR_LEN_FULL;
          end else if (fmt == FMT_SAME) begin
            need = HDR_LEN_SAME;
          end
          if (hbc_next >= need) begin
            hd_go = 1'b1;
          end
        end
        PH_EXT: begin
          ha0_next = {ha0[23:0], p1_byte};
          hbc_next = hbc + 4'd1;
          if (hbc_next >= EXT_TS_BYTES) begin
            ap_go  = 1'b1;
            ap_ext = 1'b1;
            field  = ha0_next;
          end
        end
        PH_BODY: begin
          if (cbl == 31'd0) begin
            ph_next = PH_BASIC;
          end else begin
            body_go = 1'b1;
          end
        end
        default: ph_next = PH_BASIC;
      endcase

      if (bd_go) begin
        if (cur_next >= 17'(STREAM_SLOTS)) begin
          err_go = 1'b1; err_code = ERR_CSID_RANGE;
        end else if (fmt_next != FMT_FULL && !slot_valid[p1_addr]) begin
          err_go = 1'b1; err_code = ERR_NO_STATE;
        end else begin
          cont_next = slot_valid[p1_addr] && (r.received != 24'd0);
          if (cont_next && fmt_next != FMT_CONT) begin
            err_go = 1'b1; err_code = ERR_INTERRUPTED;
          end else begin
            ha0_next = 32'd0; ha1_next = 24'd0; ha2_next = 8'd0; ha3_next = 32'd0;
            hbc_next = 4'd0;
            if (fmt_next == FMT_CONT) begin
              hd_go = 1'b1;
            end else begin
              ph_next = PH_HDR;
            end
          end
        end
      end

      if (hd_go) begin
        if (fmt_next == FMT_CONT ? r.extended : (ha0_next[23:0] == TS_ESCAPE)) begin
          ph_next  = PH_EXT;
          hbc_next = 4'd0;
          ha0_next = 32'd0;
        end else begin
          ap_go = 1'b1;
          field = ha0_next;
        end
      end

      if (ap_go) begin
        rec_we = 1'b1;
        if (fmt_next == FMT_FULL) begin
          r.length   = ha1_next;
          r.mtype    = ha2_next;
          r.mstream  = ha3_next;
          r.delta    = 32'd0;
          r.time_abs = field;
          r.extended = ap_ext;
        end else if (fmt_next != FMT_CONT) begin
          if (fmt_next == FMT_SAME) begin
            r.length = ha1_next;
            r.mtype  = ha2_next;
          end
          r.delta = field;
          if (!cont_next) begin
            r.time_abs = r.time_abs + field;
          end
          r.extended = ap_ext;
        end else if (!cont_next) begin
          r.time_abs = r.time_abs + r.delta;
        end
        if (!cont_next) begin
          r.received = 24'd0;
          r.tail     = 32'd0;
        end
        if (r.length > max_len) begin
          err_go = 1'b1; err_code = ERR_TOO_LONG;
        end else begin
          valid_set = 1'b1;
          remaining = r.length - r.received;
          csize = (acs == 31'd0) ? 31'd1 : acs;
          if (r.length == 24'd0) begin
            ph_next = PH_BASIC;
            emit_go = 1'b1; emit_kind = KIND_EMPTY; emit_last = 1'b1;
          end else begin
            cbl_next = ({7'd0, remaining} < csize) ? {7'd0, remaining} : csize;
            ph_next  = PH_BODY;
          end
        end
      end

      if (body_go) begin
        rec_we = 1'b1;
        r.received = r.received + 24'd1;
        r.tail = {r.tail[23:0], p1_byte};
        cbl_next = cbl - 31'd1;
        if (cbl_next == 31'd0) begin
          ph_next = PH_BASIC;
        end
        emit_go = 1'b1;
        if (r.received >= r.length) begin
          emit_last  = 1'b1;
          r.received = 24'd0;
          if (r.mtype == SET_CHUNK_SIZE_TYPE && r.length == SET_CHUNK_SIZE_LEN) begin
            req = r.tail[30:0];
            if (req == 31'd0) begin
              err_go = 1'b1; err_code = ERR_ZERO_CHUNK;
            end else begin
              acs_next = req;
            end
          end
        end
      end

      if (err_go) begin
        sticky_next = 1'b1;
        ph_next     = PH_BASIC;
        res_v       = 1'b1;
        res_kind    = KIND_ERROR;
        res_code    = err_code;
      end else if (emit_go) begin
        res_v    = 1'b1;
        res_kind = emit_kind;
        res_byte = (emit_kind == KIND_PAYLOAD) ? p1_byte : 8'd0;
        res_last = emit_last;
      end
    end

    // Writing the initial chunk size register loads the active chunk size.
    if (cfg_valid && cfg_ready && cfg_index == REG_INIT_CHUNK) begin
      acs_next = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_len    <= RESET_MAX_LENGTH;
      phase      <= PH_BASIC;
      hbc        <= 4'd0;
      ha0        <= 32'd0;
      ha1        <= 24'd0;
      ha2        <= 8'd0;
      ha3        <= 32'd0;
      fmt        <= FMT_FULL;
      cur        <= 17'd0;
      cbl        <= 31'd0;
      acs        <= RESET_CHUNK_SIZE;
      sticky     <= 1'b0;
      cont       <= 1'b0;
      slot_valid <= '0;
      p1_v       <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      phase  <= ph_next;
      hbc    <= hbc_next;
      ha0    <= ha0_next;
      ha1    <= ha1_next;
      ha2    <= ha2_next;
      ha3    <= ha3_next;
      fmt    <= fmt_next;
      cur    <= cur_next;
      cbl    <= cbl_next;
      acs    <= acs_next;
      sticky <= sticky_next;
      cont   <= cont_next;
      if (valid_set) begin
        slot_valid[p1_addr] <= 1'b1;
      end
      if (cfg_valid && cfg_ready && cfg_index == REG_MAX_LENGTH) begin
        max_len <= cfg_data[23:0];
      end
      if (accept) begin
        p1_v <= 1'b1;
      end else if (adv) begin
        p1_v <= 1'b0;
      end
      if (adv) begin
        out_valid <= res_v;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk) begin
    if (accept) begin
      p1_byte <= stream_byte;
      p1_addr <= raddr;
      fwd_hit <= rec_we && (p1_addr == raddr);
      wrec    <= r;
    end
    if (adv && res_v) begin
      result_kind     <= res_kind;
      payload_byte    <= res_byte;
      chunk_stream    <= cur_next;
      last_of_message <= res_last;
      error_code      <= res_code;
      if (res_kind == KIND_ERROR) begin
        message_kind   <= 8'd0;
        message_stream <= 32'd0;
        message_time   <= 32'd0;
        msg_length     <= 24'd0;
      end else begin
        message_kind   <= r.mtype;
        message_stream <= r.mstream;
        message_time   <= r.time_abs;
        msg_length     <= r.length;
      end
    end
  end

endmodule

`default_nettype wire
